// ===== sv/hptc_pkg.sv =====
// ============================================================================
// hptc_pkg: shared types, constants and helpers
// Request structures, coefficient bundle and arithmetic helpers for the
// compensation pipeline.
// ============================================================================
package hptc_pkg;

    localparam int unsigned DIV_W = 64;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic [2:0] REG_TEMP   = 3'd0;
    localparam logic [2:0] REG_PLOW   = 3'd1;
    localparam logic [2:0] REG_PHIGH  = 3'd2;
    localparam logic [2:0] REG_MIXED  = 3'd3;
    localparam logic [2:0] REG_HUM    = 3'd4;

    localparam logic [19:0] SKIP_PT = 20'h80000;
    localparam logic [15:0] SKIP_H  = 16'h8000;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } t_in_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic [16:0]        humidity_q22_10;
    } t_out_req;

    // Coefficients already sign or zero extended to the widths the datapath uses.
    typedef struct packed {
        logic [15:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [15:0] p1;
        logic [16:0] p2;
        logic [16:0] p3;
        logic [16:0] p4;
        logic [16:0] p5;
        logic [16:0] p6;
        logic [16:0] p7;
        logic [16:0] p8;
        logic [16:0] p9;
        logic [7:0]  h1;
        logic [31:0] h2;
        logic [31:0] h3;
        logic [31:0] h4;
        logic [31:0] h5;
        logic [31:0] h6;
    } t_coef;

    // Side information that rides along with the division.
    typedef struct packed {
        logic        skip;
        logic        dz;
        logic        neg;
        logic [31:0] temp;
        logic [16:0] hum;
    } t_dside;

    function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
        logic signed [31:0] s;
        s = x;
        return s >>> n;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
        logic signed [63:0] s;
        s = x;
        return s >>> n;
    endfunction

    // Low 64 bits of a 64-bit word times a signed 17-bit factor.
    function automatic logic [63:0] mul64s(logic [63:0] a, logic [16:0] b);
        logic signed [80:0] r;
        r = $signed(a) * $signed(b);
        return r[63:0];
    endfunction

endpackage

// ===== sv/hptc_front.sv =====
// ============================================================================
// hptc_front: temperature, humidity and pressure operand stages
// Sixteen register stages that produce t_fine, temperature, humidity and the
// magnitudes of the pressure dividend and divisor.
// ============================================================================
module hptc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  hptc_pkg::t_in_req i_data,
    input  hptc_pkg::t_coef  i_coef,
    output logic             o_valid,
    output logic [63:0]      o_an,
    output logic [63:0]      o_ad,
    output hptc_pkg::t_dside o_side
);

    logic [15:0] r_v;
    logic [15:0] r_skip;
    logic [19:0] r_adcp [0:8];
    logic [15:0] r_adch [0:5];
    logic [31:0] r_temp [0:11];

    logic [31:0] r1_a1, r1_a2, r2_m1, r2_m2, r3_var1, r3_m3, r4_tf;
    logic [63:0] r5_v1;
    logic [31:0] r5_x;
    logic [63:0] r6_sqlo;
    logic [31:0] r6_sqc, r6_xh6, r6_xh3, r6_h5x;
    logic [63:0] r_v1p5 [0:2];
    logic [63:0] r_v1p2 [0:2];
    logic [63:0] r7_sq;
    logic [31:0] r_hi [0:4];
    logic [31:0] r7_tin, r7_u;
    logic [63:0] r8_m6, r8_m3p;
    logic [31:0] r8_inner;
    logic [63:0] r9_v2, r9_w;
    logic [31:0] r9_in2;
    logic [63:0] r10_vv, r10_num0;
    logic [31:0] r10_lom;
    logic [63:0] r11_d, r11_num;
    logic [31:0] r11_lo;
    logic [63:0] r_an [0:4];
    logic [63:0] r_ad [0:4];
    logic        r_neg [0:4];
    logic        r_dz [0:4];
    logic [31:0] r_hx [0:3];
    logic [31:0] r13_y, r14_yy, r15_m;
    logic [16:0] r16_hum;

    logic        c_skip;
    logic [20:0] c_p0;
    logic [31:0] c_xf;
    logic [16:0] c_hum;

    always_comb begin
        c_skip = (i_data.raw_pressure == hptc_pkg::SKIP_PT) ||
                 (i_data.raw_temperature == hptc_pkg::SKIP_PT) ||
                 (i_data.raw_humidity == hptc_pkg::SKIP_H);
        c_p0 = 21'd1048576 - {1'b0, r_adcp[8]};
        c_xf = r_hx[3] - hptc_pkg::asr32(r15_m, 4);
        // Negative humidity clamps to zero, large values to 100 percent.
        if (c_xf[31]) begin
            c_hum = '0;
        end else if (c_xf > 32'd419430400) begin
            c_hum = 17'd102400;
        end else begin
            c_hum = c_xf[28:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[14:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_skip  <= {r_skip[14:0], c_skip};
            r_adcp[0] <= i_data.raw_pressure;
            for (int i = 1; i < 9; i++) r_adcp[i] <= r_adcp[i-1];
            r_adch[0] <= i_data.raw_humidity;
            for (int i = 1; i < 6; i++) r_adch[i] <= r_adch[i-1];

            // Temperature.
            r1_a1   <= 32'(i_data.raw_temperature >> 3) - {15'd0, i_coef.t1, 1'b0};
            r1_a2   <= 32'(i_data.raw_temperature >> 4) - {16'd0, i_coef.t1};
            r2_m1   <= r1_a1 * i_coef.t2;
            r2_m2   <= r1_a2 * r1_a2;
            r3_var1 <= hptc_pkg::asr32(r2_m1, 11);
            r3_m3   <= hptc_pkg::asr32(r2_m2, 12) * i_coef.t3;
            r4_tf   <= r3_var1 + hptc_pkg::asr32(r3_m3, 14);
            r_temp[0] <= hptc_pkg::asr32(r4_tf * 32'd5 + 32'd128, 8);
            for (int i = 1; i < 12; i++) r_temp[i] <= r_temp[i-1];
            r5_v1   <= {{32{r4_tf[31]}}, r4_tf} - 64'd128000;
            r5_x    <= r4_tf - 32'd76800;

            // Square of v1 from 32-bit partial products.
            r6_sqlo   <= {32'd0, r5_v1[31:0]} * {32'd0, r5_v1[31:0]};
            r6_sqc    <= r5_v1[31:0] * r5_v1[63:32];
            r_v1p5[0] <= hptc_pkg::mul64s(r5_v1, i_coef.p5);
            r_v1p2[0] <= hptc_pkg::mul64s(r5_v1, i_coef.p2);
            for (int i = 1; i < 3; i++) begin
                r_v1p5[i] <= r_v1p5[i-1];
                r_v1p2[i] <= r_v1p2[i-1];
            end
            r6_xh6 <= r5_x * i_coef.h6;
            r6_xh3 <= r5_x * i_coef.h3;
            r6_h5x <= i_coef.h5 * r5_x;

            r7_sq   <= r6_sqlo + {r6_sqc[30:0], 33'd0};
            r_hi[0] <= hptc_pkg::asr32((32'(r_adch[5]) << 14) - (i_coef.h4 << 20)
                                       - r6_h5x + 32'd16384, 15);
            for (int i = 1; i < 5; i++) r_hi[i] <= r_hi[i-1];
            r7_tin  <= hptc_pkg::asr32(r6_xh6, 10);
            r7_u    <= hptc_pkg::asr32(r6_xh3, 11) + 32'd32768;

            r8_m6    <= hptc_pkg::mul64s(r7_sq, i_coef.p6);
            r8_m3p   <= hptc_pkg::mul64s(r7_sq, i_coef.p3);
            r8_inner <= r7_tin * r7_u;

            r9_v2  <= r8_m6 + {r_v1p5[2][46:0], 17'd0}
                      + {{12{i_coef.p4[16]}}, i_coef.p4, 35'd0};
            r9_w   <= hptc_pkg::asr64(r8_m3p, 8) + {r_v1p2[2][51:0], 12'd0};
            r9_in2 <= hptc_pkg::asr32(r8_inner, 10) + 32'd2097152;

            r10_vv   <= hptc_pkg::mul64s(64'h0000_8000_0000_0000 + r9_w, {1'b0, i_coef.p1});
            r10_num0 <= {12'd0, c_p0, 31'd0} - r9_v2;
            r10_lom  <= r9_in2 * i_coef.h2;

            r11_d   <= hptc_pkg::asr64(r10_vv, 33);
            r11_num <= hptc_pkg::mul64s(r10_num0, 17'd3125);
            r11_lo  <= hptc_pkg::asr32(r10_lom + 32'd8192, 14);

            // Signed division is done on magnitudes; the sign is restored later.
            r_an[0]  <= r11_num[63] ? (64'd0 - r11_num) : r11_num;
            r_ad[0]  <= r11_d[63] ? (64'd0 - r11_d) : r11_d;
            r_neg[0] <= r11_num[63] ^ r11_d[63];
            r_dz[0]  <= (r11_d == 64'd0);
            for (int i = 1; i < 5; i++) begin
                r_an[i]  <= r_an[i-1];
                r_ad[i]  <= r_ad[i-1];
                r_neg[i] <= r_neg[i-1];
                r_dz[i]  <= r_dz[i-1];
            end
            r_hx[0] <= r_hi[4] * r11_lo;
            for (int i = 1; i < 4; i++) r_hx[i] <= r_hx[i-1];
            r13_y   <= hptc_pkg::asr32(r_hx[0], 15);
            r14_yy  <= r13_y * r13_y;
            r15_m   <= hptc_pkg::asr32(r14_yy, 7) * {24'd0, i_coef.h1};
            r16_hum <= c_hum;
        end
    end

    assign o_valid     = r_v[15];
    assign o_an        = r_an[4];
    assign o_ad        = r_ad[4];
    assign o_side.skip = r_skip[15];
    assign o_side.dz   = r_dz[4];
    assign o_side.neg  = r_neg[4];
    assign o_side.temp = r_temp[11];
    assign o_side.hum  = r16_hum;

endmodule

// ===== sv/hptc_div.sv =====
// ============================================================================
// hptc_div: pipelined unsigned divider
// Restoring division, one quotient bit per register stage.
// ============================================================================
module hptc_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [63:0]      i_an,
    input  logic [63:0]      i_ad,
    input  hptc_pkg::t_dside i_side,
    output logic             o_valid,
    output logic [63:0]      o_q,
    output hptc_pkg::t_dside o_side
);

    localparam int unsigned N = hptc_pkg::DIV_W;

    logic [N-1:0]     r_v;
    logic [63:0]      r_rem  [0:N-1];
    logic [63:0]      r_nq   [0:N-1];
    logic [63:0]      r_ad   [0:N-1];
    hptc_pkg::t_dside r_side [0:N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [63:0]      c_rem, c_nq, c_ad;
        hptc_pkg::t_dside c_side;
        logic [64:0]      c_s, c_diff;

        if (k == 0) begin : g_first
            assign c_rem  = '0;
            assign c_nq   = i_an;
            assign c_ad   = i_ad;
            assign c_side = i_side;
        end else begin : g_next
            assign c_rem  = r_rem[k-1];
            assign c_nq   = r_nq[k-1];
            assign c_ad   = r_ad[k-1];
            assign c_side = r_side[k-1];
        end

        assign c_s    = {c_rem, c_nq[63]};
        assign c_diff = c_s - {1'b0, c_ad};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= c_diff[64] ? c_s[63:0] : c_diff[63:0];
                r_nq[k]   <= {c_nq[62:0], ~c_diff[64]};
                r_ad[k]   <= c_ad;
                r_side[k] <= c_side;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_q     = r_nq[N-1];
    assign o_side  = r_side[N-1];

endmodule

// ===== sv/hptc_back.sv =====
// ============================================================================
// hptc_back: pressure correction and result stages
// Applies the quotient sign, the P7..P9 correction and builds the result.
// ============================================================================
module hptc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [63:0]       i_q,
    input  hptc_pkg::t_dside  i_side,
    input  hptc_pkg::t_coef   i_coef,
    output logic              o_valid,
    output hptc_pkg::t_out_req o_data
);

    logic [5:0]         r_v;
    hptc_pkg::t_dside   r_side [0:4];
    logic [63:0]        r_p [0:4];
    logic [63:0]        r_a, r_m8, r_sqlo, r_sq2, r_m9;
    logic [31:0]        r_sqc;
    logic [63:0]        r_v2c [0:2];
    hptc_pkg::t_out_req r_out;
    logic [63:0]        c_pf;
    hptc_pkg::t_out_req c_out;

    always_comb begin
        c_pf = hptc_pkg::asr64(r_p[4] + hptc_pkg::asr64(r_m9, 25) + r_v2c[2], 8)
               + {{43{i_coef.p7[16]}}, i_coef.p7, 4'd0};
        c_out = '0;
        if (r_side[4].skip) begin
            c_out.status = hptc_pkg::ST_SKIP;
        end else if (r_side[4].dz) begin
            c_out.status = hptc_pkg::ST_DIVZ;
        end else begin
            c_out.status            = hptc_pkg::ST_OK;
            c_out.temperature_centi = r_side[4].temp;
            c_out.pressure_q24_8    = c_pf[31:0];
            c_out.humidity_q22_10   = r_side[4].hum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_p[0]    <= i_side.neg ? (64'd0 - i_q) : i_q;
            for (int i = 1; i < 5; i++) begin
                r_side[i] <= r_side[i-1];
                r_p[i]    <= r_p[i-1];
            end
            r_a    <= hptc_pkg::asr64(r_p[0], 13);
            r_m8   <= hptc_pkg::mul64s(r_p[0], i_coef.p8);
            // Square of p >> 13 from 32-bit partial products.
            r_sqlo   <= {32'd0, r_a[31:0]} * {32'd0, r_a[31:0]};
            r_sqc    <= r_a[31:0] * r_a[63:32];
            r_v2c[0] <= hptc_pkg::asr64(r_m8, 19);
            for (int i = 1; i < 3; i++) r_v2c[i] <= r_v2c[i-1];
            r_sq2  <= r_sqlo + {r_sqc[30:0], 33'd0};
            r_m9   <= hptc_pkg::mul64s(r_sq2, i_coef.p9);
            r_out  <= c_out;
        end
    end

    assign o_valid = r_v[5];
    assign o_data  = r_out;

endmodule

// ===== sv/humidity_pressure_temp_compensation_core.sv =====
// ============================================================================
// humidity_pressure_temp_compensation_core: environmental sensor compensation
// Integer compensation of raw temperature, pressure and humidity samples.
// ============================================================================
// From an accepted request to its result the path runs through 16 operand
// stages, 64 divider stages (one quotient bit each) and 6 correction stages.
// Throughput is one request per cycle when not stalled; the one-bit-per-stage
// divider sets the depth. A stall on the result side freezes every stage at once.
// Reset clears all stage valid bits and the coefficient registers to zero.
module humidity_pressure_temp_compensation_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hptc_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hptc_pkg::t_out_req o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    // Coefficient registers, one per 8-byte slot.
    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_low;
    logic [63:0] r_press_high;
    logic [47:0] r_mixed_coeffs;
    logic [39:0] r_hum_coeffs;

    logic             w_en;
    logic             w_wr;
    hptc_pkg::t_coef  w_coef;
    logic             w_f_valid, w_d_valid;
    logic [63:0]      w_an, w_ad, w_q;
    hptc_pkg::t_dside w_f_side, w_d_side;

    // The whole pipeline advances unless a finished result is held back.
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;
    assign pready     = 1'b1;
    assign w_wr       = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs  <= '0;
            r_press_low    <= '0;
            r_press_high   <= '0;
            r_mixed_coeffs <= '0;
            r_hum_coeffs   <= '0;
        end else if (w_wr) begin
            unique case (paddr[5:3])
                hptc_pkg::REG_TEMP:  r_temp_coeffs  <= pwdata[47:0];
                hptc_pkg::REG_PLOW:  r_press_low    <= pwdata;
                hptc_pkg::REG_PHIGH: r_press_high   <= pwdata;
                hptc_pkg::REG_MIXED: r_mixed_coeffs <= pwdata[47:0];
                hptc_pkg::REG_HUM:   r_hum_coeffs   <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            hptc_pkg::REG_TEMP:  prdata = {16'd0, r_temp_coeffs};
            hptc_pkg::REG_PLOW:  prdata = r_press_low;
            hptc_pkg::REG_PHIGH: prdata = r_press_high;
            hptc_pkg::REG_MIXED: prdata = {16'd0, r_mixed_coeffs};
            hptc_pkg::REG_HUM:   prdata = {24'd0, r_hum_coeffs};
            default:             prdata = '0;
        endcase
    end

    // Unpack the calibration fields with the signedness the datapath expects.
    always_comb begin
        w_coef.t1 = r_temp_coeffs[15:0];
        w_coef.t2 = {{16{r_temp_coeffs[31]}}, r_temp_coeffs[31:16]};
        w_coef.t3 = {{16{r_temp_coeffs[47]}}, r_temp_coeffs[47:32]};
        w_coef.p1 = r_press_low[15:0];
        w_coef.p2 = {r_press_low[31], r_press_low[31:16]};
        w_coef.p3 = {r_press_low[47], r_press_low[47:32]};
        w_coef.p4 = {r_press_low[63], r_press_low[63:48]};
        w_coef.p5 = {r_press_high[15], r_press_high[15:0]};
        w_coef.p6 = {r_press_high[31], r_press_high[31:16]};
        w_coef.p7 = {r_press_high[47], r_press_high[47:32]};
        w_coef.p8 = {r_press_high[63], r_press_high[63:48]};
        w_coef.p9 = {r_mixed_coeffs[15], r_mixed_coeffs[15:0]};
        w_coef.h1 = r_mixed_coeffs[23:16];
        w_coef.h2 = {{16{r_mixed_coeffs[39]}}, r_mixed_coeffs[39:24]};
        w_coef.h3 = {24'd0, r_mixed_coeffs[47:40]};
        w_coef.h4 = {{16{r_hum_coeffs[15]}}, r_hum_coeffs[15:0]};
        w_coef.h5 = {{16{r_hum_coeffs[31]}}, r_hum_coeffs[31:16]};
        w_coef.h6 = {{24{r_hum_coeffs[39]}}, r_hum_coeffs[39:32]};
    end

    // Operand stages: temperature, humidity and the division operands.
    hptc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_coef  (w_coef),
        .o_valid (w_f_valid),
        .o_an    (w_an),
        .o_ad    (w_ad),
        .o_side  (w_f_side)
    );

    // Pressure division on magnitudes.
    hptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_an    (w_an),
        .i_ad    (w_ad),
        .i_side  (w_f_side),
        .o_valid (w_d_valid),
        .o_q     (w_q),
        .o_side  (w_d_side)
    );

    // Final pressure correction and the output register.
    hptc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_valid),
        .i_q     (w_q),
        .i_side  (w_d_side),
        .i_coef  (w_coef),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

`ifndef SYNTH
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status != 2'd3))
        else $error("result status code out of range");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != hptc_pkg::ST_OK)) |->
        ((o_out_data.temperature_centi == 32'sd0) && (o_out_data.pressure_q24_8 == 32'd0)
         && (o_out_data.humidity_q22_10 == 17'd0)))
        else $error("error result carries nonzero values");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.humidity_q22_10 <= 17'd102400))
        else $error("humidity above full scale");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && (paddr[5:3] == hptc_pkg::REG_PLOW)) |=> (r_press_low == $past(pwdata)))
        else $error("pressure coefficient write lost");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the environmental sensor compensation core
// Drives raw pressure, temperature and humidity requests through the core,
// predicts each compensated result with an independent integer model of the
// scheme, and checks every result field by field. Coefficients are written
// over the register port between phases, covering reset, typical, zero,
// all-ones and random settings.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int LONG_HOLD      = 400;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    hptc_pkg::t_in_req  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    hptc_pkg::t_out_req o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [5:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;

    humidity_pressure_temp_compensation_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Shadow copies of the coefficient registers used by the predictor.
    logic [63:0] temp_coeffs, press_lo, press_hi, mixed_coeffs, hum_coeffs;

    hptc_pkg::t_in_req  pending_samples[$];
    hptc_pkg::t_out_req expected_readings[$];

    int  error_count;
    int  samples_sent;
    int  readings_checked;
    int  skip_seen;
    int  divz_seen;
    bit  idling_enabled;
    int  idle_cycles;

    // Sign extension helpers for the packed coefficient fields.
    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx16w(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Integer compensation of one raw sample under the current coefficients.
    function automatic hptc_pkg::t_out_req compensate(hptc_pkg::t_in_req s);
        logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
        logic [31:0] adc_t, adc_h, a, m, y, var1, var2, tf, x, hi, lo, inner, hsc;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, p, q, num, an, ad;
        hptc_pkg::t_out_req r;
        r = '0;
        if (s.raw_pressure == hptc_pkg::SKIP_PT || s.raw_temperature == hptc_pkg::SKIP_PT
            || s.raw_humidity == hptc_pkg::SKIP_H) begin
            r.status = hptc_pkg::ST_SKIP;
            return r;
        end
        t1 = {16'd0, temp_coeffs[15:0]};
        t2 = sx16(temp_coeffs[31:16]);
        t3 = sx16(temp_coeffs[47:32]);
        p1 = {48'd0, press_lo[15:0]};
        p2 = sx16w(press_lo[31:16]);
        p3 = sx16w(press_lo[47:32]);
        p4 = sx16w(press_lo[63:48]);
        p5 = sx16w(press_hi[15:0]);
        p6 = sx16w(press_hi[31:16]);
        p7 = sx16w(press_hi[47:32]);
        p8 = sx16w(press_hi[63:48]);
        p9 = sx16w(mixed_coeffs[15:0]);
        h1 = {24'd0, mixed_coeffs[23:16]};
        h2 = sx16(mixed_coeffs[39:24]);
        h3 = {24'd0, mixed_coeffs[47:40]};
        h4 = sx16(hum_coeffs[15:0]);
        h5 = sx16(hum_coeffs[31:16]);
        h6 = {{24{hum_coeffs[39]}}, hum_coeffs[39:32]};
        adc_t = {12'd0, s.raw_temperature};
        adc_h = {16'd0, s.raw_humidity};

        // Temperature and the fine-temperature intermediate.
        a = (adc_t >> 3) - (t1 << 1);
        m = a * t2;
        var1 = $signed(m) >>> 11;
        a = (adc_t >> 4) - t1;
        m = a * a;
        m = $signed(m) >>> 12;
        m = m * t3;
        var2 = $signed(m) >>> 14;
        tf = var1 + var2;
        m = tf * 32'd5 + 32'd128;
        m = $signed(m) >>> 8;

        // Pressure divisor; every shift goes through a temporary so that it
        // stays arithmetic.
        v1 = {{32{tf[31]}}, tf} - 64'd128000;
        v2 = v1 * v1 * p6;
        q = v1 * p5;
        v2 = v2 + (q << 17) + (p4 << 35);
        q = v1 * v1 * p3;
        q = $signed(q) >>> 8;
        p = v1 * p2;
        v1 = q + (p << 12);
        v1 = (64'h0000_8000_0000_0000 + v1) * p1;
        v1 = $signed(v1) >>> 33;
        if (v1 == 64'd0) begin
            r.status = hptc_pkg::ST_DIVZ;
            return r;
        end
        r.temperature_centi = m;

        // Signed division truncating toward zero.
        p = 64'd1048576 - {44'd0, s.raw_pressure};
        num = ((p << 31) - v2) * 64'd3125;
        an = num[63] ? -num : num;
        ad = v1[63] ? -v1 : v1;
        q = an / ad;
        p = (num[63] ^ v1[63]) ? -q : q;
        v2 = $signed(p) >>> 13;
        v1 = p9 * v2 * v2;
        v1 = $signed(v1) >>> 25;
        v2 = p8 * p;
        v2 = $signed(v2) >>> 19;
        q = p + v1 + v2;
        q = $signed(q) >>> 8;
        p = q + (p7 << 4);
        r.pressure_q24_8 = p[31:0];

        // Humidity, clamped before the final scaling.
        x = tf - 32'd76800;
        m = (adc_h << 14) - (h4 << 20) - h5 * x + 32'd16384;
        hi = $signed(m) >>> 15;
        m = x * h6;
        m = $signed(m) >>> 10;
        y = x * h3;
        y = $signed(y) >>> 11;
        inner = m * (y + 32'd32768);
        inner = $signed(inner) >>> 10;
        inner = inner + 32'd2097152;
        m = inner * h2 + 32'd8192;
        lo = $signed(m) >>> 14;
        x = hi * lo;
        y = $signed(x) >>> 15;
        m = y * y;
        m = $signed(m) >>> 7;
        m = m * h1;
        m = $signed(m) >>> 4;
        x = x - m;
        if (x[31]) begin
            x = 32'd0;
        end else if (x > 32'd419430400) begin
            x = 32'd419430400;
        end
        hsc = x >> 12;
        r.humidity_q22_10 = hsc[16:0];
        r.status = hptc_pkg::ST_OK;
        return r;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Request driver: offers queued samples, with random idle bursts.
    int sender_gap;
    always @(posedge i_clk) begin
        hptc_pkg::t_out_req pred;
        logic               next_valid;
        next_valid = i_in_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            sender_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                pred = compensate(i_in_data);
                expected_readings.push_back(pred);
                samples_sent++;
                if (pred.status == hptc_pkg::ST_SKIP) skip_seen++;
                if (pred.status == hptc_pkg::ST_DIVZ) divz_seen++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (sender_gap > 0) begin
                    sender_gap--;
                end else if (pending_samples.size() > 0) begin
                    i_in_data <= pending_samples.pop_front();
                    next_valid = 1'b1;
                    if (idling_enabled && $urandom_range(0, 7) == 0) begin
                        sender_gap = $urandom_range(1, 15);
                    end
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // Result monitor: checks each accepted result against the oldest
    // prediction, and stalls at random. Once, after a few hundred results,
    // it holds off for a long stretch so the pipeline fills and backs up.
    int  receiver_gap;
    int  long_hold_left;
    bit  long_hold_done;
    always @(posedge i_clk) begin
        hptc_pkg::t_out_req want;
        logic               next_stall;
        next_stall = 1'b0;
        if (!i_rst_n) begin
            receiver_gap = 0;
            long_hold_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                readings_checked++;
                if (expected_readings.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    error_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (o_out_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, o_out_data.status);
                        error_count++;
                    end
                    if (o_out_data.temperature_centi !== want.temperature_centi) begin
                        $error("temperature_centi: expected %0d, actual %0d",
                               want.temperature_centi, o_out_data.temperature_centi);
                        error_count++;
                    end
                    if (o_out_data.pressure_q24_8 !== want.pressure_q24_8) begin
                        $error("pressure_q24_8: expected %0d, actual %0d",
                               want.pressure_q24_8, o_out_data.pressure_q24_8);
                        error_count++;
                    end
                    if (o_out_data.humidity_q22_10 !== want.humidity_q22_10) begin
                        $error("humidity_q22_10: expected %0d, actual %0d",
                               want.humidity_q22_10, o_out_data.humidity_q22_10);
                        error_count++;
                    end
                end
            end
            if (!long_hold_done && readings_checked >= 400) begin
                long_hold_done = 1'b1;
                long_hold_left = LONG_HOLD;
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                next_stall = 1'b1;
            end else if (receiver_gap > 0) begin
                receiver_gap--;
                next_stall = 1'b1;
            end else if (idling_enabled && $urandom_range(0, 7) == 0) begin
                receiver_gap = $urandom_range(0, 14);
                next_stall = 1'b1;
            end
        end
        i_out_stall <= next_stall;
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Register write over the APB-style port; the shadow copy follows.
    task automatic write_coeffs(logic [2:0] idx, logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            hptc_pkg::REG_TEMP:  temp_coeffs  = value & 64'h0000_FFFF_FFFF_FFFF;
            hptc_pkg::REG_PLOW:  press_lo     = value;
            hptc_pkg::REG_PHIGH: press_hi     = value;
            hptc_pkg::REG_MIXED: mixed_coeffs = value & 64'h0000_FFFF_FFFF_FFFF;
            hptc_pkg::REG_HUM:   hum_coeffs   = value & 64'h0000_00FF_FFFF_FFFF;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [63:0] tc, logic [63:0] pl, logic [63:0] ph,
                             logic [63:0] mc, logic [63:0] hc);
        write_coeffs(hptc_pkg::REG_TEMP, tc);
        write_coeffs(hptc_pkg::REG_PLOW, pl);
        write_coeffs(hptc_pkg::REG_PHIGH, ph);
        write_coeffs(hptc_pkg::REG_MIXED, mc);
        write_coeffs(hptc_pkg::REG_HUM, hc);
    endtask

    // Sender pause: wait until every outstanding request has its result, then
    // let the pipeline settle before touching the registers. The check runs
    // on the falling edge so that the driver's updates are already visible.
    task automatic drain;
        while (pending_samples.size() > 0 || i_in_valid || expected_readings.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic hptc_pkg::t_in_req sample(logic [19:0] pr, logic [19:0] tr,
                                                 logic [15:0] hr);
        hptc_pkg::t_in_req s;
        s.raw_pressure = pr;
        s.raw_temperature = tr;
        s.raw_humidity = hr;
        return s;
    endfunction

    // Random sample: mostly plausible readings, some uniform noise, and an
    // occasional skipped-measurement sentinel on one of the channels.
    function automatic hptc_pkg::t_in_req random_sample();
        hptc_pkg::t_in_req s;
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 9) begin
            s = sample(20'($urandom_range(250000, 600000)),
                       20'($urandom_range(400000, 600000)),
                       16'($urandom_range(20000, 40000)));
        end else begin
            s = sample(20'($urandom), 20'($urandom), 16'($urandom));
        end
        case ($urandom_range(0, 23))
            0: s.raw_pressure = hptc_pkg::SKIP_PT;
            1: s.raw_temperature = hptc_pkg::SKIP_PT;
            2: s.raw_humidity = hptc_pkg::SKIP_H;
            default: ;
        endcase
        return s;
    endfunction

    task automatic random_phase(int count);
        repeat (count) pending_samples.push_back(random_sample());
        drain();
    endtask

    // Typical factory calibration of a real part.
    localparam logic [63:0] TYP_TEMP  = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PLOW  = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_PHIGH = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [63:0] TYP_MIXED = {16'd0, 8'd0, 16'd362, 8'd75, 16'd6000};
    localparam logic [63:0] TYP_HUM   = {24'd0, 8'd30, 16'd0, 16'd324};

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        temp_coeffs = '0;
        press_lo = '0;
        press_hi = '0;
        mixed_coeffs = '0;
        hum_coeffs = '0;
        error_count = 0;
        samples_sent = 0;
        readings_checked = 0;
        skip_seen = 0;
        divz_seen = 0;
        idling_enabled = 1'b1;
        long_hold_done = 1'b0;
        idle_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset coefficients: the pressure divisor is zero for any sample.
        pending_samples.push_back(sample(20'd415148, 20'd519888, 16'd29000));
        pending_samples.push_back(sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
        pending_samples.push_back(sample(hptc_pkg::SKIP_PT, 20'd519888, 16'd29000));
        drain();

        // Directed samples under the typical calibration.
        write_all(TYP_TEMP, TYP_PLOW, TYP_PHIGH, TYP_MIXED, TYP_HUM);
        pending_samples.push_back(sample(20'd415148, 20'd519888, 16'd29000));
        pending_samples.push_back(sample(20'd0, 20'd0, 16'd0));
        pending_samples.push_back(sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
        pending_samples.push_back(sample(20'd0, 20'hFFFFF, 16'hFFFF));
        pending_samples.push_back(sample(20'hFFFFF, 20'd0, 16'd0));
        pending_samples.push_back(sample(hptc_pkg::SKIP_PT, 20'd519888, 16'd29000));
        pending_samples.push_back(sample(20'd415148, hptc_pkg::SKIP_PT, 16'd29000));
        pending_samples.push_back(sample(20'd415148, 20'd519888, hptc_pkg::SKIP_H));
        pending_samples.push_back(sample(hptc_pkg::SKIP_PT, hptc_pkg::SKIP_PT,
                                         hptc_pkg::SKIP_H));
        pending_samples.push_back(sample(20'h7FFFF, 20'h80001, 16'h7FFF));
        pending_samples.push_back(sample(20'd415148, 20'd519888, 16'd65000));
        pending_samples.push_back(sample(20'd415148, 20'd519888, 16'd1));
        pending_samples.push_back(sample(20'd300000, 20'd600000, 16'd40000));
        drain();

        // Extreme coefficients: all ones, then all zero, then a zero P1 only.
        write_all('1, '1, '1, '1, '1);
        pending_samples.push_back(sample(20'd415148, 20'd519888, 16'd29000));
        pending_samples.push_back(sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
        pending_samples.push_back(sample(20'd0, 20'd0, 16'd0));
        random_phase(120);
        write_all('0, '0, '0, '0, '0);
        random_phase(40);
        write_all(TYP_TEMP, TYP_PLOW & ~64'hFFFF, TYP_PHIGH, TYP_MIXED, TYP_HUM);
        random_phase(40);

        // Typical calibration with random samples; the long receiver hold
        // happens in this phase.
        write_all(TYP_TEMP, TYP_PLOW, TYP_PHIGH, TYP_MIXED, TYP_HUM);
        random_phase(600);

        // Fully random coefficients, several settings.
        repeat (4) begin
            write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
            random_phase(200);
        end

        // Typical calibration again, streaming with no idling at all.
        write_all(TYP_TEMP, TYP_PLOW, TYP_PHIGH, TYP_MIXED, TYP_HUM);
        idling_enabled = 1'b0;
        random_phase(330);

        $display("Checked %0d results from %0d requests (%0d skipped, %0d zero divisor).",
                 readings_checked, samples_sent, skip_seen, divz_seen);
        $display("Coefficient settings: reset, typical, zero, all ones and random.");
        if (error_count == 0 && expected_readings.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/hptc_pkg.sv
sv/hptc_front.sv
sv/hptc_div.sv
sv/hptc_back.sv
sv/humidity_pressure_temp_compensation_core.sv
tb/tb_top.sv
